>>> rtl/core/ira_pkg.sv
// Shared types, constants and helpers for the integer to radix ASCII converter.
// No dependencies; every other file in rtl/core except ira_ram imports this package.
package ira_pkg;

  // Field widths
  localparam int VALUE_WIDTH = 32;
  localparam int BASE_WIDTH  = 6;
  localparam int CHAR_WIDTH  = 7;
  localparam int DIGIT_WIDTH = 6;

  // Divider chunking: eight quotient bits per cycle
  localparam int CHUNK      = 8;
  localparam int NCHUNK     = (VALUE_WIDTH + CHUNK - 1) / CHUNK;
  localparam int PAD_WIDTH  = NCHUNK * CHUNK;
  localparam int CNT_WIDTH  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  // Digit stack: at most one digit per value bit (base 2)
  localparam int MAX_DIGITS = VALUE_WIDTH;
  localparam int STACK_AW   = $clog2(MAX_DIGITS);

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  // Radix limits
  localparam logic [BASE_WIDTH-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_WIDTH-1:0] BASE_TEN = 6'd10;

  // Character codes
  localparam logic [CHAR_WIDTH-1:0] CHAR_NONE  = 7'h00;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ALPHA = 7'h41;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LAST_DIGIT = 7'h39;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LAST_ALPHA = 7'h5A;
  localparam logic [CHAR_WIDTH-1:0] DECIMAL_DIGITS  = 7'd10;

  // Input request
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [BASE_WIDTH-1:0]         base;
  } in_req_t;

  // Output request
  typedef struct packed {
    logic [CHAR_WIDTH-1:0] char_code;
    logic                  last;
    logic                  bad_base;
  } out_req_t;

  // Job classification
  typedef enum logic [1:0] {
    JOB_DIGITS,
    JOB_ZERO,
    JOB_BAD
  } job_kind_e;

  typedef struct packed {
    job_kind_e              kind;
    logic                   neg;
    logic [BASE_WIDTH-1:0]  base;
    logic [VALUE_WIDTH-1:0] mag;
  } job_t;

  // Map a digit value 0..35 to its ASCII character
  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] dw;
    dw = {1'b0, d};
    if (dw < DECIMAL_DIGITS) begin
      return CHAR_ZERO + dw;
    end
    return CHAR_ALPHA + (dw - DECIMAL_DIGITS);
  endfunction

endpackage

>>> rtl/core/integer_to_radix_ascii.sv
// Top level of the integer to radix ASCII converter: front end, job queue, back end.
// Depends on ira_pkg, ira_front, ira_queue, ira_back.
//
//   channel   direction  handshake          payload
//   request   in         push / full        data_i   (value, base)
//   result    out        pop / empty        data_o   (char_code, last, bad_base)
//
// A zero value or a bad radix yields its lone result character straight from idle.
// Otherwise each digit takes one alignment step plus one divide step per significant
// 8-bit chunk of the running quotient in the shared divider, and each character
// passes through the digit stack read port as a read request, then the read data.
// Reset clears the queue, the sequencer and the result valid flag; no clearing pass.
// A stalled result holds the back end at its next character; the two-entry job queue keeps taking requests until full.
module integer_to_radix_ascii (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ira_pkg::in_req_t   data_i,
  input  logic               push,
  output logic               full,
  output ira_pkg::out_req_t  data_o,
  output logic               empty,
  input  logic               pop
);
  import ira_pkg::*;

  job_t front_job;
  job_t queue_job;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  // Classify incoming requests
  ira_front u_front (
    .data_i   (data_i),
    .push_i   (push),
    .full_o   (full),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .job_o    (front_job)
  );

  // Buffer classified jobs
  ira_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (queue_job),
    .empty_o (q_empty)
  );

  // Convert and emit characters
  ira_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (queue_job),
    .job_empty_i (q_empty),
    .job_pop_o   (q_pop),
    .res_o       (data_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  // A bad radix result is a lone null character
  a_bad_base_lone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && data_o.bad_base) |-> (data_o.last && data_o.char_code == CHAR_NONE))
    else $error("bad radix result is not a lone terminating null");

  // A minus sign never ends a string
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && data_o.char_code == CHAR_MINUS) |-> (!data_o.last && !data_o.bad_base))
    else $error("minus sign marked as last or bad radix");

  // Every good result is a digit, a letter or a minus sign
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !data_o.bad_base) |->
      ((data_o.char_code >= CHAR_ZERO && data_o.char_code <= CHAR_LAST_DIGIT) ||
       (data_o.char_code >= CHAR_ALPHA && data_o.char_code <= CHAR_LAST_ALPHA) ||
       (data_o.char_code == CHAR_MINUS)))
    else $error("result character outside the digit alphabet");

  // A job popped from the queue never coincides with an idle queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end took a job from an empty queue");

endmodule

>>> rtl/core/ira_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ira_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; hold data while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ira_front.sv
// Front end: accepts requests and classifies them into converter jobs.
// Depends on ira_pkg.
module ira_front (
  input  ira_pkg::in_req_t data_i,
  input  logic             push_i,
  output logic             full_o,
  input  logic             q_full_i,
  output logic             q_push_o,
  output ira_pkg::job_t    job_o
);
  import ira_pkg::*;

  logic                   bad;
  logic                   zero;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] raw;

  // Accept whenever the job queue has room
  assign full_o   = q_full_i;
  assign q_push_o = push_i & ~q_full_i;

  // Classify: bad radix, zero, signed decimal
  assign raw  = data_i.value;
  assign bad  = (data_i.base < BASE_MIN) || (data_i.base > BASE_MAX);
  assign zero = (raw == '0);
  assign neg  = (data_i.base == BASE_TEN) && raw[VALUE_WIDTH-1];

  always_comb begin
    job_o.neg  = neg;
    job_o.base = data_i.base;
    job_o.mag  = neg ? (~raw + 1'b1) : raw;
    if (bad) begin
      job_o.kind = JOB_BAD;
    end else if (zero) begin
      job_o.kind = JOB_ZERO;
    end else begin
      job_o.kind = JOB_DIGITS;
    end
  end

endmodule

>>> rtl/core/ira_queue.sv
// Short job queue decoupling the front end from the conversion back end.
// Depends on ira_pkg.
module ira_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ira_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output ira_pkg::job_t job_o,
  output logic          empty_o
);
  import ira_pkg::*;

  job_t                  slot_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_WIDTH-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = (cnt_q == QCNT_WIDTH'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign job_o   = slot_q[rd_ptr_q];

  // Advance pointers with wrap, track fill
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store job payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> rtl/core/ira_back.sv
// Back end: divides by the radix eight bits a cycle, stacks digits, emits them reversed.
// Depends on ira_pkg and ira_ram.
module ira_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ira_pkg::job_t    job_i,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  output ira_pkg::out_req_t res_o,
  output logic             empty_o,
  input  logic             pop_i
);
  import ira_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NORM = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_RDA  = 3'd4;
  localparam logic [2:0] S_RDW  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [BASE_WIDTH-1:0]  base_q, base_d;
  logic                   neg_q, neg_d;
  logic [PAD_WIDTH-1:0]   dvd_q, dvd_d;
  logic [DIGIT_WIDTH-1:0] rem_q, rem_d;
  logic [CNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic [STACK_AW:0]      nd_q, nd_d;
  logic [STACK_AW-1:0]    rd_idx_q, rd_idx_d;
  out_req_t               out_q, out_d;
  logic                   out_v_q, out_v_d;

  logic                   out_free;
  logic [PAD_WIDTH-1:0]   dvd_norm;
  logic [CNT_WIDTH-1:0]   top_chunk;
  logic [PAD_WIDTH-1:0]   dvd_next;
  logic [DIGIT_WIDTH-1:0] rem_next;
  logic                   ram_we;
  logic                   ram_re;
  logic [DIGIT_WIDTH-1:0] ram_rdata;

  assign out_free = ~out_v_q | pop_i;
  assign empty_o  = ~out_v_q;
  assign res_o    = out_q;

  // Find the highest nonzero chunk and align it to the top
  always_comb begin
    dvd_norm  = dvd_q;
    top_chunk = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      if (|dvd_q[c*CHUNK +: CHUNK]) begin
        dvd_norm  = dvd_q << (CHUNK * (NCHUNK - 1 - c));
        top_chunk = CNT_WIDTH'(c);
      end
    end
  end

  // Eight restoring division steps on the top chunk
  always_comb begin
    logic [DIGIT_WIDTH:0] r;
    logic [DIGIT_WIDTH:0] t;
    logic [CHUNK-1:0]     chunk;
    logic [CHUNK-1:0]     q;
    r     = {1'b0, rem_q};
    chunk = dvd_q[PAD_WIDTH-1 -: CHUNK];
    q     = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      t = {r[DIGIT_WIDTH-1:0], chunk[i]};
      if (t >= {1'b0, base_q}) begin
        r    = t - {1'b0, base_q};
        q[i] = 1'b1;
      end else begin
        r = t;
      end
    end
    rem_next = r[DIGIT_WIDTH-1:0];
    dvd_next = (dvd_q << CHUNK) | PAD_WIDTH'(q);
  end

  // Sequencer: answer zero and bad radix jobs directly, else take job, divide digit by digit, then emit sign and digits
  always_comb begin
    state_d   = state_q;
    base_d    = base_q;
    neg_d     = neg_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    nd_d      = nd_q;
    rd_idx_d  = rd_idx_q;
    out_d     = out_q;
    out_v_d   = out_v_q & ~pop_i;
    job_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          case (job_i.kind)
            JOB_DIGITS: begin
              job_pop_o = 1'b1;
              base_d    = job_i.base;
              neg_d     = job_i.neg;
              dvd_d     = PAD_WIDTH'(job_i.mag);
              nd_d      = '0;
              state_d   = S_NORM;
            end
            JOB_ZERO: begin
              if (out_free) begin
                job_pop_o       = 1'b1;
                out_d.char_code = CHAR_ZERO;
                out_d.last      = 1'b1;
                out_d.bad_base  = 1'b0;
                out_v_d         = 1'b1;
              end
            end
            default: begin
              if (out_free) begin
                job_pop_o       = 1'b1;
                out_d.char_code = CHAR_NONE;
                out_d.last      = 1'b1;
                out_d.bad_base  = 1'b1;
                out_v_d         = 1'b1;
              end
            end
          endcase
        end
      end
      S_NORM: begin
        dvd_d   = dvd_norm;
        cnt_d   = top_chunk;
        rem_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        dvd_d = dvd_next;
        rem_d = rem_next;
        if (cnt_q == '0) begin
          ram_we = 1'b1;
          nd_d   = nd_q + 1'b1;
          if (dvd_next == '0) begin
            rd_idx_d = nd_q[STACK_AW-1:0];
            state_d  = neg_q ? S_SIGN : S_RDA;
          end else begin
            state_d = S_NORM;
          end
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_d.char_code = CHAR_MINUS;
          out_d.last      = 1'b0;
          out_d.bad_base  = 1'b0;
          out_v_d         = 1'b1;
          state_d         = S_RDA;
        end
      end
      S_RDA: begin
        ram_re  = 1'b1;
        state_d = S_RDW;
      end
      S_RDW: begin
        if (out_free) begin
          out_d.char_code = digit_char(ram_rdata);
          out_d.last      = (rd_idx_q == '0);
          out_d.bad_base  = 1'b0;
          out_v_d         = 1'b1;
          if (rd_idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - 1'b1;
            state_d  = S_RDA;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    neg_q    <= neg_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    nd_q     <= nd_d;
    rd_idx_q <= rd_idx_d;
    out_q    <= out_d;
  end

  // Digit stack, least significant digit at address zero
  ira_ram #(
    .WIDTH (DIGIT_WIDTH),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (nd_q[STACK_AW-1:0]),
    .wdata_i (rem_next),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

endmodule
